>>> rtl/direction_yaw_pitch_angles_unit_defines.svh
// Assertion macros for the direction angle unit.
// All checks sample on the rising edge of clk and are off while arst_n is low.
`ifndef DIRECTION_YAW_PITCH_ANGLES_UNIT_DEFINES_SVH
`define DIRECTION_YAW_PITCH_ANGLES_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DYPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DYPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dypa_pkg.sv
package dypa_pkg;

	localparam int DW  = 33;      // point difference
	localparam int CW  = 61;      // CORDIC x/y datapath
	localparam int AW  = 34;      // angle, degrees Q24
	localparam int KW  = 25;      // gain constant
	localparam int MW  = DW + KW; // |d| * gain, unsigned
	localparam int YW  = 26;      // yaw out
	localparam int PW  = 24;      // pitch out
	localparam int SH  = 24;      // input pre-scale shift
	localparam int RSH = 8;       // Q24 -> Q16

	localparam logic [KW-1:0]        GAIN_Q    = 25'd27628053;
	localparam logic signed [AW-1:0] ANG_90    = 34'sd1509949440;
	localparam logic signed [AW-1:0] ANG_180   = 34'sd3019898880;
	localparam logic signed [AW-1:0] RND_HALF  = 34'sd128;
	localparam logic signed [YW-1:0] YAW_LO    = -26'sd17694720;
	localparam logic signed [YW-1:0] YAW_HI    = 26'sd5898240;
	localparam logic signed [YW-1:0] PITCH_LIM = 26'sd5898240;

	// atan(2^-i) in degrees, Q24
	localparam logic [29:0] ATAN_TAB [32] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
		30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
		30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
		30'd234684,    30'd117342,    30'd58671,     30'd29335,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115,
		30'd57,        30'd29,        30'd14,        30'd7,
		30'd4,         30'd2,         30'd1,         30'd0
	};

	typedef struct packed {
		logic signed [31:0] from_x;
		logic signed [31:0] from_y;
		logic signed [31:0] from_z;
		logic signed [31:0] to_x;
		logic signed [31:0] to_y;
		logic signed [31:0] to_z;
	} in_t;

	typedef struct packed {
		logic signed [YW-1:0] yaw_deg;
		logic signed [PW-1:0] pitch_deg;
	} out_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] ang;
	} vec_t;

	// carried alongside the azimuth rotator
	typedef struct packed {
		logic                 hz;       // dx == dz == 0
		logic                 byp;      // on an axis, azimuth is exact
		logic                 dy_zero;
		logic signed [AW-1:0] az_axis;
		logic [MW-1:0]        hor_axis;
		logic signed [MW:0]   dyk;      // dy * gain
	} side1_t;

	// carried alongside the elevation rotator
	typedef struct packed {
		logic signed [AW-1:0] az;
		logic                 el_byp;
		logic signed [AW-1:0] el_val;
	} side2_t;

endpackage

>>> rtl/dypa_cordic_cell.sv
module dypa_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           prev_valid,
	input  dypa_pkg::vec_t prev_vec,
	output logic           next_valid,
	output dypa_pkg::vec_t next_vec
);
	import dypa_pkg::*;

	localparam logic [4:0] TIDX = 5'(IDX);

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [AW-1:0] da;
	vec_t                 rot;

	// floor shifts, direction from the sign of y
	always_comb begin
		xs = prev_vec.x >>> IDX;
		ys = prev_vec.y >>> IDX;
		da = $signed({{(AW-30){1'b0}}, ATAN_TAB[TIDX]});
		if (!prev_vec.y[CW-1]) begin
			rot.x   = prev_vec.x + ys;
			rot.y   = prev_vec.y - xs;
			rot.ang = prev_vec.ang + da;
		end else begin
			rot.x   = prev_vec.x - ys;
			rot.y   = prev_vec.y + xs;
			rot.ang = prev_vec.ang - da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_valid <= 1'b0;
		end else if (en) begin
			next_valid <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_vec <= rot;
		end
	end

endmodule

>>> rtl/dypa_cordic_chain.sv
module dypa_cordic_chain #(
	parameter int STAGES = 24,
	parameter int SW     = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           prev_valid,
	input  dypa_pkg::vec_t prev_vec,
	input  logic [SW-1:0]  prev_side,
	output logic           next_valid,
	output dypa_pkg::vec_t next_vec,
	output logic [SW-1:0]  next_side
);
	import dypa_pkg::*;

	vec_t          vec_w   [STAGES+1];
	logic          valid_w [STAGES+1];
	logic [SW-1:0] side_q  [STAGES];

	assign vec_w[0]   = prev_vec;
	assign valid_w[0] = prev_valid;

	for (genvar g = 0; g < STAGES; g++) begin : g_cell
		dypa_cordic_cell #(
			.IDX(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.prev_valid(valid_w[g]),
			.prev_vec  (vec_w[g]),
			.next_valid(valid_w[g+1]),
			.next_vec  (vec_w[g+1])
		);
	end

	// sideband delay line, one tap per cell
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= prev_side;
			for (int i = 1; i < STAGES; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	assign next_valid = valid_w[STAGES];
	assign next_vec   = vec_w[STAGES];
	assign next_side  = side_q[STAGES-1];

endmodule

>>> rtl/direction_yaw_pitch_angles_unit.sv
// Path: an input transfer passes s1, s2, the azimuth CORDIC cells, s3, the elevation CORDIC
// cells, s4 and the output register, where it raises out_valid.
// Throughput: one point pair per cycle while the skid entry is empty; every stage, including
// both rows of CORDIC cells, is a single register rank, so a new transfer is taken each cycle.
// Stalls: output register plus one skid entry; in_ready drops only while the skid is full.
// Reset: arst_n asynchronously clears every valid bit and the skid; data regs are not reset.
`include "direction_yaw_pitch_angles_unit_defines.svh"

module direction_yaw_pitch_angles_unit #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dypa_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output dypa_pkg::out_t out_data
);
	import dypa_pkg::*;

	// Whole pipeline advances together; it stops only when the skid entry holds a result.
	logic en;

	//------------------------------------------------------------------
	// s1: difference vector, 33 bits per component
	//------------------------------------------------------------------
	logic                 v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {in_data.to_x[31], in_data.to_x} - {in_data.from_x[31], in_data.from_x};
			dy_s1 <= {in_data.to_y[31], in_data.to_y} - {in_data.from_y[31], in_data.from_y};
			dz_s1 <= {in_data.to_z[31], in_data.to_z} - {in_data.from_z[31], in_data.from_z};
		end
	end

	//------------------------------------------------------------------
	// s2: axis detection, gain products, left half plane pre-rotation
	//------------------------------------------------------------------
	logic                 dxz, dzz;
	logic [DW-1:0]        mag;
	logic signed [CW-1:0] xw, zw;
	vec_t                 vec1_w;
	side1_t               side1_w;

	always_comb begin
		dxz = (dx_s1 == '0);
		dzz = (dz_s1 == '0);

		side1_w.hz      = dxz & dzz;
		side1_w.byp     = dxz | dzz;
		side1_w.dy_zero = (dy_s1 == '0);

		// exact angle on an axis; zero vector gives zero
		if (dxz && dzz) begin
			side1_w.az_axis = '0;
		end else if (dzz) begin
			side1_w.az_axis = dx_s1[DW-1] ? ANG_180 : '0;
		end else begin
			side1_w.az_axis = dz_s1[DW-1] ? -ANG_90 : ANG_90;
		end

		// horizontal length on an axis: |component| * gain
		if (dzz) begin
			mag = dx_s1[DW-1] ? -dx_s1 : dx_s1;
		end else begin
			mag = dz_s1[DW-1] ? -dz_s1 : dz_s1;
		end
		side1_w.hor_axis = MW'(mag) * MW'(GAIN_Q);
		side1_w.dyk      = (MW+1)'(dy_s1) * (MW+1)'($signed({1'b0, GAIN_Q}));

		// scale by 2^24, then turn by 90 degrees when x < 0
		xw = {{(CW-DW-SH){dx_s1[DW-1]}}, dx_s1, {SH{1'b0}}};
		zw = {{(CW-DW-SH){dz_s1[DW-1]}}, dz_s1, {SH{1'b0}}};
		if (!dx_s1[DW-1]) begin
			vec1_w.x   = xw;
			vec1_w.y   = zw;
			vec1_w.ang = '0;
		end else if (!dz_s1[DW-1]) begin
			vec1_w.x   = zw;
			vec1_w.y   = -xw;
			vec1_w.ang = ANG_90;
		end else begin
			vec1_w.x   = -zw;
			vec1_w.y   = xw;
			vec1_w.ang = -ANG_90;
		end
	end

	logic   v_s2;
	vec_t   vec_s2;
	side1_t side1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s2   <= vec1_w;
			side1_s2 <= side1_w;
		end
	end

	//------------------------------------------------------------------
	// azimuth rotator: atan2(dz, dx) and gain-scaled horizontal length
	//------------------------------------------------------------------
	logic                        c1_valid;
	vec_t                        c1_vec;
	logic [$bits(side1_t)-1:0]   c1_side_w;
	side1_t                      c1_side;

	dypa_cordic_chain #(
		.STAGES(CORDIC_STAGES),
		.SW    ($bits(side1_t))
	) u_azim (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.prev_valid(v_s2),
		.prev_vec  (vec_s2),
		.prev_side (side1_s2),
		.next_valid(c1_valid),
		.next_vec  (c1_vec),
		.next_side (c1_side_w)
	);

	assign c1_side = c1_side_w;

	//------------------------------------------------------------------
	// s3: pick azimuth, set up elevation vector (hor, dy * gain)
	//------------------------------------------------------------------
	vec_t   vec2_w;
	side2_t side2_w;

	always_comb begin
		side2_w.az = c1_side.byp ? c1_side.az_axis : c1_vec.ang;
		vec2_w.x   = c1_side.byp ? {{(CW-MW){1'b0}}, c1_side.hor_axis} : c1_vec.x;
		vec2_w.y   = {{(CW-MW-1){c1_side.dyk[MW]}}, c1_side.dyk};
		vec2_w.ang = '0;

		// flat direction, or straight up/down
		side2_w.el_byp = c1_side.dy_zero | c1_side.hz;
		if (c1_side.dy_zero) begin
			side2_w.el_val = '0;
		end else begin
			side2_w.el_val = c1_side.dyk[MW] ? -ANG_90 : ANG_90;
		end
	end

	logic   v_s3;
	vec_t   vec_s3;
	side2_t side2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= c1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s3   <= vec2_w;
			side2_s3 <= side2_w;
		end
	end

	//------------------------------------------------------------------
	// elevation rotator
	//------------------------------------------------------------------
	logic                      c2_valid;
	vec_t                      c2_vec;
	logic [$bits(side2_t)-1:0] c2_side_w;
	side2_t                    c2_side;

	dypa_cordic_chain #(
		.STAGES(CORDIC_STAGES),
		.SW    ($bits(side2_t))
	) u_elev (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.prev_valid(v_s3),
		.prev_vec  (vec_s3),
		.prev_side (side2_s3),
		.next_valid(c2_valid),
		.next_vec  (c2_vec),
		.next_side (c2_side_w)
	);

	assign c2_side = c2_side_w;

	//------------------------------------------------------------------
	// s4: yaw = az - 90, pitch = -el; round half up to Q16 and clamp
	//------------------------------------------------------------------
	logic signed [AW-1:0] el;
	logic signed [AW-1:0] yaw_sum, pitch_sum;
	logic signed [YW-1:0] yaw_q, pitch_q;
	logic signed [YW-1:0] pitch_c;
	out_t                 res_w;

	always_comb begin
		el        = c2_side.el_byp ? c2_side.el_val : c2_vec.ang;
		yaw_sum   = c2_side.az + (RND_HALF - ANG_90);
		pitch_sum = RND_HALF - el;
		yaw_q     = yaw_sum[AW-1:RSH];
		pitch_q   = pitch_sum[AW-1:RSH];

		if (yaw_q < YAW_LO) begin
			res_w.yaw_deg = YAW_LO;
		end else if (yaw_q > YAW_HI) begin
			res_w.yaw_deg = YAW_HI;
		end else begin
			res_w.yaw_deg = yaw_q;
		end

		if (pitch_q < -PITCH_LIM) begin
			pitch_c = -PITCH_LIM;
		end else if (pitch_q > PITCH_LIM) begin
			pitch_c = PITCH_LIM;
		end else begin
			pitch_c = pitch_q;
		end
		res_w.pitch_deg = pitch_c[PW-1:0];
	end

	logic v_s4;
	out_t res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= c2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res_w;
		end
	end

	//------------------------------------------------------------------
	// output register and skid entry
	// When en is high s4 always moves on, so its result lands in the
	// output register if that is free or being taken, else in the skid.
	//------------------------------------------------------------------
	logic out_valid_q, skid_valid_q;
	out_t out_q, skid_q;
	logic out_free;

	assign out_free = ~out_valid_q | out_ready;
	assign en       = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= v_s4;
			end
		end else if (en && v_s4) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res_s4;
		end
		if (!out_free && en && v_s4) begin
			skid_q <= res_s4;
		end
	end

	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	//------------------------------------------------------------------
	// checks
	//------------------------------------------------------------------
	logic out_in_range;

	assign out_in_range = (out_q.yaw_deg >= YAW_LO) && (out_q.yaw_deg <= YAW_HI)
		&& (out_q.pitch_deg >= -PW'(PITCH_LIM)) && (out_q.pitch_deg <= PW'(PITCH_LIM));

	`DYPA_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
	`DYPA_ASSERT_NEXT(a_skid_keeps_out, skid_valid_q, out_valid_q, "output lost after skid")
	`DYPA_ASSERT_NOW(a_out_range, out_valid_q, out_in_range, "angle out of range")

endmodule
